/* hw/rtl/cubic_bezier_easing_eval_macros.svh */
// Assertion macros for the cubic-Bezier easing evaluator.
// Taken in by the top level; no other dependencies.
`ifndef CUBIC_BEZIER_EASING_EVAL_MACROS_SVH
`define CUBIC_BEZIER_EASING_EVAL_MACROS_SVH

// same-cycle implication
`define CBE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CBE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cbe_pkg.sv */
// Shared types, constants and the microcode ROM of the easing evaluator.
// No dependencies; used by the channel interfaces and the top level.
package cbe_pkg;

   localparam int TQ    = 24;          // fraction bits of t
   localparam int TW    = TQ + 1;      // t-domain word, holds 1.0
   localparam int MA_W  = TQ + 3;      // multiplier A operand, holds 3 * value
   localparam int MP_W  = MA_W + TW;   // t-domain product
   localparam int REG_W = 18;
   localparam int IN_W  = 17;
   localparam int OUT_W = 19;
   localparam int OUT_MAX = 262143;
   localparam int OUT_MIN = -262144;

   localparam logic [TW-1:0] T_ONE  = TW'(1) << TQ;
   localparam logic [TW-1:0] T_HALF = TW'(1) << (TQ - 1);

   localparam logic signed [REG_W-1:0] CTRL1_X_RST = '0;
   localparam logic signed [REG_W-1:0] CTRL1_Y_RST = '0;
   localparam logic signed [REG_W-1:0] CTRL2_X_RST = REG_W'(65536);
   localparam logic signed [REG_W-1:0] CTRL2_Y_RST = REG_W'(65536);

   typedef enum logic [1:0] {
      CSR_CTRL1_X = 2'd0,
      CSR_CTRL1_Y = 2'd1,
      CSR_CTRL2_X = 2'd2,
      CSR_CTRL2_Y = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_MUL_RT2,
      OP_MUL_TT,
      OP_MUL_W1,
      OP_MUL_W2,
      OP_MUL_W3,
      OP_ACC1,
      OP_ACC2,
      OP_ACC3,
      OP_BISECT,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_SEARCH
   } cond_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } st_type;

   localparam int PC_W = 5;
   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      op_type   op;
      logic     coord_y;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   function automatic ucode_type uword(op_type op, logic coord_y, cond_type cond,
                                       pc_type target);
      ucode_type w;
      w.op      = op;
      w.coord_y = coord_y;
      w.cond    = cond;
      w.target  = target;
      return w;
   endfunction

   // x evaluation, bisection test, y evaluation, emit
   function automatic ucode_type ucode_rom(pc_type pc);
      ucode_type w;
      case (pc)
         5'd0:    w = uword(OP_MUL_RT2, 1'b0, COND_NEVER,  '0);
         5'd1:    w = uword(OP_MUL_TT,  1'b0, COND_NEVER,  '0);
         5'd2:    w = uword(OP_MUL_W1,  1'b0, COND_NEVER,  '0);
         5'd3:    w = uword(OP_MUL_W2,  1'b0, COND_NEVER,  '0);
         5'd4:    w = uword(OP_MUL_W3,  1'b0, COND_NEVER,  '0);
         5'd5:    w = uword(OP_ACC1,    1'b0, COND_NEVER,  '0);
         5'd6:    w = uword(OP_ACC2,    1'b0, COND_NEVER,  '0);
         5'd7:    w = uword(OP_ACC3,    1'b0, COND_NEVER,  '0);
         5'd8:    w = uword(OP_BISECT,  1'b0, COND_SEARCH, '0);
         5'd9:    w = uword(OP_MUL_RT2, 1'b1, COND_NEVER,  '0);
         5'd10:   w = uword(OP_MUL_TT,  1'b1, COND_NEVER,  '0);
         5'd11:   w = uword(OP_MUL_W1,  1'b1, COND_NEVER,  '0);
         5'd12:   w = uword(OP_MUL_W2,  1'b1, COND_NEVER,  '0);
         5'd13:   w = uword(OP_MUL_W3,  1'b1, COND_NEVER,  '0);
         5'd14:   w = uword(OP_ACC1,    1'b1, COND_NEVER,  '0);
         5'd15:   w = uword(OP_ACC2,    1'b1, COND_NEVER,  '0);
         5'd16:   w = uword(OP_ACC3,    1'b1, COND_NEVER,  '0);
         5'd17:   w = uword(OP_EMIT,    1'b1, COND_ALWAYS, '0);
         default: w = uword(OP_MUL_RT2, 1'b0, COND_ALWAYS, '0);
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/cbe_req_if.sv */
// Request channel of the easing evaluator: valid/ready plus progress.
// Depends on cbe_pkg for the field width.
interface cbe_req_if;
   logic                      valid;
   logic                      ready;
   logic [cbe_pkg::IN_W-1:0]  progress;

   modport source (output valid, output progress, input ready);
   modport sink   (input valid, input progress, output ready);
endinterface

/* hw/rtl/cbe_rsp_if.sv */
// Response channel of the easing evaluator: valid/ready plus eased value.
// Depends on cbe_pkg for the field width.
interface cbe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [cbe_pkg::OUT_W-1:0] eased_value;

   modport source (output valid, output eased_value, input ready);
   modport sink   (input valid, input eased_value, output ready);
endinterface

/* hw/rtl/cubic_bezier_easing_eval.sv */
// Cubic-Bezier easing evaluator: microcoded sequencer over one t-domain multiplier and
// one coefficient multiplier. Depends on cbe_pkg, the channel interfaces, the macros.
// A curve evaluation is 8 steps plus 1 for the bisection test; x is evaluated and tested
// until the bisection ends, then y is evaluated and emitted.
// One request at a time: the next is taken only after the response is emitted, and the
// emit waits on a held response. Sync active-high reset: points (0,0)/(1,1), idle.
`include "cubic_bezier_easing_eval_macros.svh"

module cubic_bezier_easing_eval #(
   parameter int MAX_STEPS = 20,
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   cbe_req_if.sink                    req_if,
   cbe_rsp_if.source                  rsp_if,
   input  logic                       csr_we,
   input  cbe_pkg::csr_index_type     csr_index,
   input  logic [cbe_pkg::REG_W-1:0]  csr_wdata
);

   localparam int TQ    = cbe_pkg::TQ;
   localparam int TW    = cbe_pkg::TW;
   localparam int MA_W  = cbe_pkg::MA_W;
   localparam int MP_W  = cbe_pkg::MP_W;
   localparam int REG_W = cbe_pkg::REG_W;
   localparam int IN_W  = cbe_pkg::IN_W;
   localparam int OUT_W = cbe_pkg::OUT_W;

   localparam int AW     = (FRAC_BITS + 1 > IN_W) ? FRAC_BITS + 1 : IN_W;
   localparam int CM_W   = REG_W + TW + 1;
   localparam int ACC_W  = TQ + ((FRAC_BITS > REG_W) ? FRAC_BITS : REG_W) + 3;
   localparam int CW     = ACC_W - TQ;
   localparam int DW     = CW + 1;
   localparam int SW     = $clog2(MAX_STEPS + 1);
   localparam int ONE_I  = 1 << FRAC_BITS;
   localparam int TOL    = (ONE_I + 5000) / 10000;

   localparam logic [AW-1:0]           ONE_A    = AW'(1) << FRAC_BITS;
   localparam logic signed [DW-1:0]    TOL_S    = DW'(TOL);
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (TQ - 1);
   localparam logic signed [CW-1:0]    SAT_HI   = CW'(cbe_pkg::OUT_MAX);
   localparam logic signed [CW-1:0]    SAT_LO   = CW'(cbe_pkg::OUT_MIN);
   localparam logic [SW-1:0]           STEP_LIM = SW'(MAX_STEPS);

   // control
   cbe_pkg::st_type    state_ff, state_in;
   cbe_pkg::pc_type    pc_ff, pc_in;
   cbe_pkg::ucode_type uw;
   logic               req_fire;
   logic               adv;
   logic               jump;
   logic               emit_fire;
   logic               searching;
   logic               rsp_valid_ff, rsp_valid_in;

   // configuration
   logic signed [REG_W-1:0] ctrl1_x_ff, ctrl1_x_in;
   logic signed [REG_W-1:0] ctrl1_y_ff, ctrl1_y_in;
   logic signed [REG_W-1:0] ctrl2_x_ff, ctrl2_x_in;
   logic signed [REG_W-1:0] ctrl2_y_ff, ctrl2_y_in;

   // datapath
   logic [AW-1:0]           a_ff, a_in;
   logic [TW-1:0]           t_ff, t_in;
   logic [TQ-1:0]           step_ff, step_in;
   logic [SW-1:0]           steps_ff, steps_in;
   logic [TW-1:0]           r1_ff, r1_in;
   logic [TW-1:0]           r2_ff, r2_in;
   logic [TW-1:0]           w1_ff, w1_in;
   logic [TW-1:0]           w2_ff, w2_in;
   logic [TW-1:0]           w3_ff, w3_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [OUT_W-1:0] eased_ff, eased_in;

   logic [TW-1:0]           rt;
   logic [MA_W-1:0]         tm_a;
   logic [TW-1:0]           tm_b;
   logic [MP_W-1:0]         tm_prod;
   logic [TW-1:0]           tm_res;
   logic [TW-1:0]           w_sel;
   logic signed [REG_W-1:0] c_sel;
   logic signed [TW:0]      w_s;
   logic signed [CM_W-1:0]  cm_prod;
   logic signed [ACC_W-1:0] w3_term;
   logic signed [CW-1:0]    cv;
   logic signed [DW-1:0]    diff;
   logic                    in_tol;
   logic [TQ-1:0]           step_half;
   logic signed [OUT_W-1:0] y_sat;

   // assertion helpers
   logic                    running;
   logic                    run_start;
   logic                    t_inside;
   logic                    rsp_raised;

   assign uw = cbe_pkg::ucode_rom(pc_ff);

   // ---------------- sequencer ----------------
   assign req_fire  = req_if.valid && req_if.ready;
   assign adv       = !(uw.op == cbe_pkg::OP_EMIT && rsp_valid_ff && !rsp_if.ready);
   assign emit_fire = (state_ff == cbe_pkg::ST_RUN) && uw.op == cbe_pkg::OP_EMIT && adv;

   always_comb begin
      case (uw.cond)
         cbe_pkg::COND_ALWAYS: jump = 1'b1;
         cbe_pkg::COND_SEARCH: jump = searching;
         default:              jump = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbe_pkg::ST_IDLE: begin
            if (req_fire) state_in = cbe_pkg::ST_RUN;
         end
         cbe_pkg::ST_RUN: begin
            if (emit_fire) state_in = cbe_pkg::ST_IDLE;
         end
         default: state_in = cbe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = (state_ff == cbe_pkg::ST_IDLE) && !reset;
      if (state_ff != cbe_pkg::ST_RUN) begin
         pc_in = '0;
      end else if (!adv) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   // ---------------- configuration ----------------
   always_comb begin
      ctrl1_x_in = ctrl1_x_ff;
      ctrl1_y_in = ctrl1_y_ff;
      ctrl2_x_in = ctrl2_x_ff;
      ctrl2_y_in = ctrl2_y_ff;
      if (csr_we) begin
         case (csr_index)
            cbe_pkg::CSR_CTRL1_X: ctrl1_x_in = signed'(csr_wdata);
            cbe_pkg::CSR_CTRL1_Y: ctrl1_y_in = signed'(csr_wdata);
            cbe_pkg::CSR_CTRL2_X: ctrl2_x_in = signed'(csr_wdata);
            cbe_pkg::CSR_CTRL2_Y: ctrl2_y_in = signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------- datapath ----------------
   assign rt = cbe_pkg::T_ONE - t_ff;

   always_comb begin
      tm_a = MA_W'(t_ff);
      tm_b = t_ff;
      case (uw.op)
         cbe_pkg::OP_MUL_RT2: begin
            tm_a = MA_W'(rt);
            tm_b = rt;
         end
         cbe_pkg::OP_MUL_W1: begin
            tm_a = MA_W'(r1_ff) + (MA_W'(r1_ff) << 1);
            tm_b = t_ff;
         end
         cbe_pkg::OP_MUL_W2: begin
            tm_a = MA_W'(rt) + (MA_W'(rt) << 1);
            tm_b = r2_ff;
         end
         cbe_pkg::OP_MUL_W3: begin
            tm_a = MA_W'(r2_ff);
            tm_b = t_ff;
         end
         default: ;
      endcase
   end

   // Q24 x Q24 rounded half up back to Q24
   assign tm_prod = MP_W'(tm_a) * MP_W'(tm_b) + MP_W'(cbe_pkg::T_HALF);
   assign tm_res  = tm_prod[TQ+TW-1:TQ];

   always_comb begin
      if (uw.op == cbe_pkg::OP_ACC2) begin
         w_sel = w2_ff;
         c_sel = uw.coord_y ? ctrl2_y_ff : ctrl2_x_ff;
      end else begin
         w_sel = w1_ff;
         c_sel = uw.coord_y ? ctrl1_y_ff : ctrl1_x_ff;
      end
   end

   assign w_s     = signed'({1'b0, w_sel});
   assign cm_prod = w_s * c_sel;
   // end point (1,1) term: w3 * 1.0
   assign w3_term = signed'(ACC_W'(w3_ff) << FRAC_BITS);

   // floor of acc / 2^24; the half was folded in at the last accumulate
   assign cv        = acc_ff[ACC_W-1:TQ];
   assign diff      = DW'(cv) - DW'(signed'({1'b0, a_ff}));
   assign in_tol    = (diff <= TOL_S) && (diff >= -TOL_S);
   assign searching = !in_tol && (steps_ff != STEP_LIM);
   assign step_half = step_ff >> 1;

   always_comb begin
      if (cv > SAT_HI) begin
         y_sat = SAT_HI[OUT_W-1:0];
      end else if (cv < SAT_LO) begin
         y_sat = SAT_LO[OUT_W-1:0];
      end else begin
         y_sat = cv[OUT_W-1:0];
      end
   end

   always_comb begin
      a_in     = a_ff;
      t_in     = t_ff;
      step_in  = step_ff;
      steps_in = steps_ff;
      r1_in    = r1_ff;
      r2_in    = r2_ff;
      w1_in    = w1_ff;
      w2_in    = w2_ff;
      w3_in    = w3_ff;
      acc_in   = acc_ff;
      eased_in = eased_ff;
      if (state_ff == cbe_pkg::ST_IDLE) begin
         if (req_fire) begin
            a_in     = (AW'(req_if.progress) > ONE_A) ? ONE_A : AW'(req_if.progress);
            t_in     = cbe_pkg::T_HALF;
            step_in  = cbe_pkg::T_HALF[TQ-1:0];
            steps_in = '0;
         end
      end else begin
         case (uw.op)
            cbe_pkg::OP_MUL_RT2: r1_in  = tm_res;
            cbe_pkg::OP_MUL_TT:  r2_in  = tm_res;
            cbe_pkg::OP_MUL_W1:  w1_in  = tm_res;
            cbe_pkg::OP_MUL_W2:  w2_in  = tm_res;
            cbe_pkg::OP_MUL_W3:  w3_in  = tm_res;
            cbe_pkg::OP_ACC1:    acc_in = ACC_W'(cm_prod);
            cbe_pkg::OP_ACC2:    acc_in = acc_ff + ACC_W'(cm_prod);
            cbe_pkg::OP_ACC3:    acc_in = acc_ff + w3_term + ACC_HALF;
            cbe_pkg::OP_BISECT: begin
               if (searching) begin
                  step_in  = step_half;
                  steps_in = steps_ff + 1'b1;
                  // no move when x equals the target
                  if (diff < 0) begin
                     t_in = t_ff + TW'(step_half);
                  end else if (diff > 0) begin
                     t_in = t_ff - TW'(step_half);
                  end
               end
            end
            cbe_pkg::OP_EMIT: begin
               if (adv) eased_in = y_sat;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = emit_fire || (rsp_valid_ff && !rsp_if.ready);

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.eased_value = eased_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbe_pkg::ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         ctrl1_x_ff   <= cbe_pkg::CTRL1_X_RST;
         ctrl1_y_ff   <= cbe_pkg::CTRL1_Y_RST;
         ctrl2_x_ff   <= cbe_pkg::CTRL2_X_RST;
         ctrl2_y_ff   <= cbe_pkg::CTRL2_Y_RST;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl1_x_ff   <= ctrl1_x_in;
         ctrl1_y_ff   <= ctrl1_y_in;
         ctrl2_x_ff   <= ctrl2_x_in;
         ctrl2_y_ff   <= ctrl2_y_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      t_ff     <= t_in;
      step_ff  <= step_in;
      steps_ff <= steps_in;
      r1_ff    <= r1_in;
      r2_ff    <= r2_in;
      w1_ff    <= w1_in;
      w2_ff    <= w2_in;
      w3_ff    <= w3_in;
      acc_ff   <= acc_in;
      eased_ff <= eased_in;
   end

   // ---------------- assertions ----------------
   assign running    = (state_ff == cbe_pkg::ST_RUN);
   assign run_start  = running && pc_ff == '0 && steps_ff == '0;
   assign t_inside   = t_ff != '0 && t_ff < cbe_pkg::T_ONE;
   assign rsp_raised = rsp_valid_ff && state_ff == cbe_pkg::ST_IDLE;

   `CBE_ASSERT_NEXT(a_start_clean, clock, reset, req_fire, run_start, "request did not start at step zero")
   `CBE_ASSERT_IMPL(a_steps_bound, clock, reset, running, steps_ff <= STEP_LIM, "step count past limit")
   `CBE_ASSERT_IMPL(a_t_interior, clock, reset, running && pc_ff != '0, t_inside, "t left the unit interval")
   `CBE_ASSERT_NEXT(a_emit_result, clock, reset, emit_fire, rsp_raised, "emit did not raise valid")

endmodule
